// ----- rtl/mf2d_pkg.sv -----
// shared constants for the 2d median filter: field widths, register indexes,
// operation codes and parameter defaults; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mf2d_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_MAX_RADIUS = 10;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int DIM_W      = 10;
    localparam int RAD_W      = 4;
    localparam int HIST_BINS  = 256;
    localparam int HIST_AW    = 8;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 10'd512;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 10'd512;
    localparam logic [RAD_W-1:0] RST_RADIUS       = 4'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/mf2d_in_if.sv -----
// input channel of the median filter: write or query items
// depends on mf2d_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mf2d_in_if;
    import mf2d_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [PIX_W-1:0]   pixel_value;

    modport source (output valid, op, x_pos, y_pos, pixel_value, input ready);
    modport sink   (input valid, op, x_pos, y_pos, pixel_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/mf2d_out_if.sv -----
// output channel of the median filter: one median per query
// depends on mf2d_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mf2d_out_if;
    import mf2d_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] median_value;

    modport source (output valid, median_value, input ready);
    modport sink   (input valid, median_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/median_filter_2d_top.sv -----
// top level of the square-window 2d median filter
// depends on mf2d_pkg, mf2d_in_if, mf2d_out_if, mf2d_ram
//
//  channel   dir  payload                          transfer when
//  pix_in    in   op, x_pos, y_pos, pixel_value    pix_in.valid && pix_in.ready
//  med_out   out  median_value                     med_out.valid && med_out.ready
//  cfg       in   cfg_index, cfg_wdata             cfg_we
//
// a write is taken in idle and leaves the sequencer idle. a query takes each window
// pixel through address, frame read, histogram read and histogram increment in turn,
// then a 256-bin scan finds the median and zeroes bins.
// after reset a clearing pass of the histogram runs before pix_in is ready.
// the finished median sits in an output register; a query only waits at its end
// while that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_2d_top #(
    parameter int MAX_WIDTH  = mf2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = mf2d_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [mf2d_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mf2d_pkg::CFG_DATA_W-1:0] cfg_wdata,
    mf2d_in_if.sink                             pix_in,
    mf2d_out_if.source                          med_out
);
    import mf2d_pkg::*;

    localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW       = $clog2(((MAX_DIM > 1023) ? MAX_DIM : 1023) + 1);
    localparam int SW       = DW + 1;
    localparam int XW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RUW      = $clog2(MAX_RADIUS + 1);
    localparam int RW       = RUW + 1;
    localparam int WIN_MAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W    = $clog2(WIN_MAX + 1);
    localparam int SCW      = HIST_AW + 1;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_ADDR = 8'b0000_0100,
        S_FRD  = 8'b0000_1000,
        S_HRD  = 8'b0001_0000,
        S_HWR  = 8'b0010_0000,
        S_SCAN = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIM_W-1:0]     frame_width_reg, frame_height_reg;
    logic [RAD_W-1:0]     radius_reg;
    logic [COORD_W-1:0]   cx_reg, cy_reg;
    logic signed [RW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [RUW-1:0]       r_reg, r_next;
    logic [CNT_W-1:0]     target_reg, target_next;
    logic [CNT_W-1:0]     seen_reg, seen_next;
    logic                 found_reg, found_next;
    logic [PIX_W-1:0]     med_reg, med_next;
    logic [AW-1:0]        addr_reg;
    logic [PIX_W-1:0]     bin_reg;
    logic [SCW-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]     out_data_reg;

    logic [DW-1:0]        eff_w, eff_h;
    logic [RUW-1:0]       eff_r;
    logic signed [SW-1:0] sx, sy;
    logic [DW-1:0]        xx, yy;
    logic [AW-1:0]        win_addr, wr_addr;
    logic [RW-1:0]        side;
    logic [2*RW-1:0]      side_sq;

    logic                 frame_we, frame_re;
    logic [PIX_W-1:0]     frame_rdata;
    logic                 hist_we, hist_re;
    logic [HIST_AW-1:0]   hist_waddr, hist_raddr;
    logic [CNT_W-1:0]     hist_wdata, hist_rdata;
    logic                 in_xfer, out_xfer;

    // effective frame size and radius
    always_comb
    begin
        eff_w = DW'(frame_width_reg);
        if (frame_width_reg == '0)
        begin
            eff_w = DW'(1);
        end
        else if (DW'(frame_width_reg) > DW'(MAX_WIDTH))
        begin
            eff_w = DW'(MAX_WIDTH);
        end
        eff_h = DW'(frame_height_reg);
        if (frame_height_reg == '0)
        begin
            eff_h = DW'(1);
        end
        else if (DW'(frame_height_reg) > DW'(MAX_HEIGHT))
        begin
            eff_h = DW'(MAX_HEIGHT);
        end
        if (32'(radius_reg) > 32'(MAX_RADIUS))
        begin
            eff_r = RUW'(MAX_RADIUS);
        end
        else
        begin
            eff_r = RUW'(radius_reg);
        end
        side    = RW'({eff_r, 1'b1});
        side_sq = (2*RW)'(side) * (2*RW)'(side);
    end

    // clamped window coordinate and its store address
    always_comb
    begin
        sx = $signed(SW'(cx_reg)) + SW'(dx_reg);
        sy = $signed(SW'(cy_reg)) + SW'(dy_reg);
        if (sx < 0)
        begin
            xx = '0;
        end
        else if (sx > $signed({1'b0, eff_w}) - 1)
        begin
            xx = eff_w - 1'b1;
        end
        else
        begin
            xx = DW'(sx);
        end
        if (sy < 0)
        begin
            yy = '0;
        end
        else if (sy > $signed({1'b0, eff_h}) - 1)
        begin
            yy = eff_h - 1'b1;
        end
        else
        begin
            yy = DW'(sy);
        end
        win_addr = AW'(yy) * AW'(MAX_WIDTH) + AW'(xx[XW-1:0]);
        wr_addr  = AW'(pix_in.y_pos) * AW'(MAX_WIDTH) + AW'(pix_in.x_pos);
    end

    assign pix_in.ready         = (state_reg == S_IDLE);
    assign in_xfer              = pix_in.valid && pix_in.ready;
    assign out_xfer             = out_valid_reg && med_out.ready;
    assign med_out.valid        = out_valid_reg;
    assign med_out.median_value = out_data_reg;

    assign frame_we = in_xfer && (pix_in.op == OP_WRITE)
                      && (DW'(pix_in.x_pos) < eff_w) && (DW'(pix_in.y_pos) < eff_h);
    assign frame_re = (state_reg == S_FRD);

    mf2d_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .waddr (wr_addr),
        .wdata (pix_in.pixel_value),
        .re    (frame_re),
        .raddr (addr_reg),
        .rdata (frame_rdata)
    );

    mf2d_ram #(
        .WIDTH (CNT_W),
        .DEPTH (HIST_BINS),
        .AW    (HIST_AW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // histogram port control
    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = scan_cnt_reg[HIST_AW-1:0];
        hist_wdata = '0;
        hist_re    = 1'b0;
        hist_raddr = scan_cnt_reg[HIST_AW-1:0];
        case (state_reg)
            S_CLR:
            begin
                hist_we = 1'b1;
            end
            S_HRD:
            begin
                hist_re    = 1'b1;
                hist_raddr = frame_rdata;
            end
            S_HWR:
            begin
                hist_we    = 1'b1;
                hist_waddr = bin_reg;
                hist_wdata = hist_rdata + 1'b1;
            end
            S_SCAN:
            begin
                hist_re = !scan_cnt_reg[HIST_AW];
                // zero the bin whose count just came back
                hist_we    = (scan_cnt_reg != '0);
                hist_waddr = HIST_AW'(scan_cnt_reg - 1'b1);
            end
            default:
            begin
                hist_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        r_next         = r_reg;
        target_next    = target_reg;
        seen_next      = seen_reg;
        found_next     = found_reg;
        med_next       = med_reg;
        scan_cnt_next  = scan_cnt_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        case (state_reg)
            S_CLR:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SCW'(HIST_BINS - 1))
                begin
                    scan_cnt_next = '0;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer && (pix_in.op == OP_QUERY))
                begin
                    r_next      = eff_r;
                    dx_next     = -$signed(RW'(eff_r));
                    dy_next     = -$signed(RW'(eff_r));
                    target_next = CNT_W'(side_sq >> 1);
                    state_next  = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_FRD;
            end
            S_FRD:
            begin
                state_next = S_HRD;
            end
            S_HRD:
            begin
                state_next = S_HWR;
            end
            S_HWR:
            begin
                state_next = S_ADDR;
                if (dx_reg == $signed(RW'(r_reg)))
                begin
                    dx_next = -$signed(RW'(r_reg));
                    if (dy_reg == $signed(RW'(r_reg)))
                    begin
                        scan_cnt_next = '0;
                        seen_next     = '0;
                        found_next    = 1'b0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        dy_next = dy_reg + 1'b1;
                    end
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg != '0)
                begin
                    seen_next = seen_reg + hist_rdata;
                    if (!found_reg && (seen_next > target_reg))
                    begin
                        found_next = 1'b1;
                        med_next   = PIX_W'(scan_cnt_reg - 1'b1);
                    end
                end
                if (scan_cnt_reg[HIST_AW])
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || med_out.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLR;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            radius_reg       <= RST_RADIUS;
            scan_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= DIM_W'(cfg_wdata);
                    CFG_FRAME_HEIGHT: frame_height_reg <= DIM_W'(cfg_wdata);
                    CFG_RADIUS:       radius_reg       <= RAD_W'(cfg_wdata);
                    default:          radius_reg       <= radius_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        r_reg      <= r_next;
        target_reg <= target_next;
        seen_reg   <= seen_next;
        med_reg    <= med_next;
        if (in_xfer)
        begin
            cx_reg <= pix_in.x_pos;
            cy_reg <= pix_in.y_pos;
        end
        if (state_reg == S_ADDR)
        begin
            addr_reg <= win_addr;
        end
        if (state_reg == S_HRD)
        begin
            bin_reg <= frame_rdata;
        end
        if (state_reg == S_DONE && state_next == S_IDLE)
        begin
            out_data_reg <= med_reg;
        end
    end

`ifndef SYNTH
    a_frame_we_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        frame_we |-> (in_xfer && pix_in.op == OP_WRITE))
        else $error("frame store written without an accepted write");

    a_no_hist_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !hist_we)
        else $error("histogram written outside a query");

    a_scan_finds_median: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && scan_cnt_reg[HIST_AW]) |-> (found_next && state_next == S_DONE))
        else $error("histogram scan ended without a median");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !med_out.ready) |=> state_reg == S_DONE)
        else $error("result overwrote a pending output");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE) |=> out_valid_reg)
        else $error("finished query gave no result");
`endif

endmodule

`default_nettype wire

// ----- rtl/mf2d_ram.sv -----
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mf2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
